[design/cqpr_pkg.sv]
// ---------------------------------------------------------------------------
// cqpr_pkg: shared types and constants of the circular queue core
// Microcode control word, step addresses, select codes, field widths and
// the control program itself.
// ---------------------------------------------------------------------------
`default_nettype none

package cqpr_pkg;

	// Field widths
	localparam int WORD_W  = 32;
	localparam int KCNT_W  = 8;
	localparam int OPC_W   = 2;
	localparam int STAT_W  = 2;
	localparam int IN_W    = 40;
	localparam int OUT_W   = 48;

	// Operation codes
	localparam logic [OPC_W-1:0] OP_PUSH    = 2'd0;
	localparam logic [OPC_W-1:0] OP_POP     = 2'd1;
	localparam logic [OPC_W-1:0] OP_REVERSE = 2'd2;
	localparam logic [OPC_W-1:0] OP_STATUS  = 2'd3;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
	localparam logic [STAT_W-1:0] ST_TOO_MANY = 2'd3;

	// Program step addresses
	typedef logic [2:0] step_t;
	localparam step_t S_IDLE = 3'd0;
	localparam step_t S_PUSH = 3'd1;
	localparam step_t S_HEAD = 3'd2;
	localparam step_t S_OUT  = 3'd3;
	localparam step_t S_RA   = 3'd4;
	localparam step_t S_RB   = 3'd5;
	localparam step_t S_WA   = 3'd6;
	localparam step_t S_WB   = 3'd7;

	// Sequencing conditions
	typedef enum logic [2:0] {
		CND_NEXT,
		CND_GOTO,
		CND_DISPATCH,
		CND_SWAP,
		CND_OUT
	} cond_t;

	// Read address, write address and write data selects
	typedef enum logic [1:0] {
		RS_HEAD,
		RS_A,
		RS_B
	} rsel_t;

	typedef enum logic [1:0] {
		WS_TAIL,
		WS_A,
		WS_B
	} wsel_t;

	typedef enum logic [1:0] {
		DS_VAL,
		DS_RD,
		DS_TMP
	} dsel_t;

	// Kind of work an accepted request starts
	typedef enum logic [1:0] {
		ENT_PUSH,
		ENT_SWAP,
		ENT_HEAD
	} entry_t;

	// One control word per program step
	typedef struct packed {
		logic  in_ready;
		logic  re;
		rsel_t rsel;
		logic  we;
		wsel_t wsel;
		dsel_t dsel;
		logic  cap_tmp;
		logic  inc_count;
		logic  step_swap;
		logic  load_out;
		cond_t cond;
		step_t target;
	} ctrl_t;

	// Datapath conditions seen by the sequencer
	typedef struct packed {
		logic   in_valid;
		entry_t kind;
		logic   swaps_more;
		logic   out_free;
	} flags_t;

	localparam ctrl_t CTRL_NOP = '{
		in_ready: 1'b0, re: 1'b0, rsel: RS_HEAD, we: 1'b0, wsel: WS_TAIL,
		dsel: DS_VAL, cap_tmp: 1'b0, inc_count: 1'b0, step_swap: 1'b0,
		load_out: 1'b0, cond: CND_NEXT, target: S_IDLE
	};

	// Control program
	function automatic ctrl_t ucode(input step_t step);
		ctrl_t c;
		c = CTRL_NOP;
		case (step)
			S_IDLE: begin
				c.in_ready = 1'b1;
				c.cond     = CND_DISPATCH;
			end
			S_PUSH: begin
				c.we        = 1'b1;
				c.wsel      = WS_TAIL;
				c.dsel      = DS_VAL;
				c.inc_count = 1'b1;
			end
			S_HEAD: begin
				c.re   = 1'b1;
				c.rsel = RS_HEAD;
			end
			S_OUT: begin
				c.load_out = 1'b1;
				c.cond     = CND_OUT;
				c.target   = S_IDLE;
			end
			S_RA: begin
				c.re   = 1'b1;
				c.rsel = RS_A;
			end
			S_RB: begin
				c.re      = 1'b1;
				c.rsel    = RS_B;
				c.cap_tmp = 1'b1;
			end
			S_WA: begin
				c.we   = 1'b1;
				c.wsel = WS_A;
				c.dsel = DS_RD;
			end
			S_WB: begin
				c.we        = 1'b1;
				c.wsel      = WS_B;
				c.dsel      = DS_TMP;
				c.step_swap = 1'b1;
				c.cond      = CND_SWAP;
				c.target    = S_RA;
			end
			default: c = CTRL_NOP;
		endcase
		return c;
	endfunction

	// Entry step of each kind of work
	function automatic step_t dispatch(input entry_t kind);
		step_t s;
		case (kind)
			ENT_PUSH: s = S_PUSH;
			ENT_SWAP: s = S_RA;
			ENT_HEAD: s = S_HEAD;
			default:  s = S_HEAD;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

[design/circular_queue_prefix_reverse_core.sv]
// Steps: a pop, status or rejected request reads the head and then loads the
// output; a push first writes the tail, a reverse of k entries first runs one
// swap for each of floor(k/2) pairs. One request runs at a time; a stalled
// result holds the output step and delays the next request. Each swap costs
// four steps on the single write port and single read port of the queue memory.
// Reset clears head pointer, count, step counter and output valid; no sweep.
// ---------------------------------------------------------------------------
// circular_queue_prefix_reverse_core: ring-buffer queue with prefix reverse
// Push, pop, status and in-place reverse of the first k entries, run by a
// microcoded sequencer over a plain datapath and one queue memory.
// ---------------------------------------------------------------------------
`default_nettype none

module circular_queue_prefix_reverse_core import cqpr_pkg::*; #(
	parameter int DEPTH = 128
) (
	input  wire              clk,
	input  wire              arst_n,
	// s_tdata: push_value [31:0], prefix_count [39:32]
	input  wire  [IN_W-1:0]  s_tdata,
	// s_tuser: operation [1:0]
	input  wire  [OPC_W-1:0] s_tuser,
	input  wire              s_tvalid,
	output logic             s_tready,
	// m_tdata: head_value [31:0], entry_count [39:32], is_empty [40],
	//          status [42:41], zero [47:43]
	output logic [OUT_W-1:0] m_tdata,
	output logic             m_tvalid,
	input  wire              m_tready
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > KCNT_W) ? CW : KCNT_W;
	localparam int SW = XW + 1;

	ctrl_t  ctrl;
	flags_t flags;

	logic [AW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     a_q;
	logic [AW-1:0]     b_q;
	logic [KCNT_W-2:0] swaps_q;
	logic [WORD_W-1:0] value_q;
	logic [WORD_W-1:0] tmp_q;
	logic [STAT_W-1:0] status_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	logic [OPC_W-1:0]  op;
	logic [WORD_W-1:0] word;
	logic [KCNT_W-1:0] k;
	logic [XW-1:0]     kx;
	logic [XW-1:0]     cx;
	logic              full;
	logic              accept;
	logic [STAT_W-1:0] status_in;
	entry_t            kind;
	logic [SW-1:0]     tail_sum;
	logic [SW-1:0]     last_sum;
	logic [AW-1:0]     tail_ptr;
	logic [AW-1:0]     last_ptr;
	logic              out_free;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	// Step a pointer forward or back around the ring
	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
	endfunction

	// Fold a sum below twice the depth back into the ring
	function automatic logic [AW-1:0] ptr_wrap(input logic [SW-1:0] s);
		logic [SW-1:0] r;
		r = (s >= SW'(DEPTH)) ? s - SW'(DEPTH) : s;
		return r[AW-1:0];
	endfunction

	// Unpack the request
	assign op   = s_tuser;
	assign word = s_tdata[WORD_W-1:0];
	assign k    = s_tdata[WORD_W+KCNT_W-1:WORD_W];
	assign kx   = XW'(k);
	assign cx   = XW'(count_q);
	assign full = (count_q == CW'(DEPTH));

	assign s_tready = ctrl.in_ready;
	assign accept   = s_tvalid && ctrl.in_ready;
	assign out_free = !out_valid_q || m_tready;

	// Ring positions of the tail and of the last entry of the prefix
	assign tail_sum = SW'(head_q) + SW'(count_q);
	assign last_sum = SW'(head_q) + SW'(kx) - 1'b1;
	assign tail_ptr = ptr_wrap(tail_sum);
	assign last_ptr = ptr_wrap(last_sum);

	// Decode status and the kind of work
	always_comb begin
		status_in = ST_OK;
		kind      = ENT_HEAD;
		case (op)
			OP_PUSH: begin
				if (full) begin
					status_in = ST_FULL;
				end else begin
					kind = ENT_PUSH;
				end
			end
			OP_POP: begin
				if (count_q == '0) begin
					status_in = ST_EMPTY;
				end
			end
			OP_REVERSE: begin
				if (kx > cx) begin
					status_in = ST_TOO_MANY;
				end else if (k > KCNT_W'(1)) begin
					kind = ENT_SWAP;
				end
			end
			OP_STATUS: status_in = ST_OK;
			default:   status_in = ST_OK;
		endcase
	end

	assign flags = '{
		in_valid:   s_tvalid,
		kind:       kind,
		swaps_more: (swaps_q > (KCNT_W-1)'(1)),
		out_free:   out_free
	};

	cqpr_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	// Memory address and data selection
	always_comb begin
		case (ctrl.rsel)
			RS_HEAD: ram_raddr = head_q;
			RS_A:    ram_raddr = a_q;
			RS_B:    ram_raddr = b_q;
			default: ram_raddr = head_q;
		endcase
		case (ctrl.wsel)
			WS_TAIL: ram_waddr = tail_ptr;
			WS_A:    ram_waddr = a_q;
			WS_B:    ram_waddr = b_q;
			default: ram_waddr = tail_ptr;
		endcase
		case (ctrl.dsel)
			DS_VAL:  ram_wdata = value_q;
			DS_RD:   ram_wdata = ram_rdata;
			DS_TMP:  ram_wdata = tmp_q;
			default: ram_wdata = value_q;
		endcase
	end

	assign ram_we = ctrl.we;

	cqpr_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ctrl.re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Queue pointer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (accept && op == OP_POP && count_q != '0) begin
			head_q  <= ptr_inc(head_q);
			count_q <= count_q - 1'b1;
		end else if (ctrl.inc_count) begin
			count_q <= count_q + 1'b1;
		end
	end

	// Latch request payload and advance swap positions
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q  <= word;
			status_q <= status_in;
			a_q      <= head_q;
			b_q      <= last_ptr;
			swaps_q  <= k[KCNT_W-1:1];
		end else if (ctrl.step_swap) begin
			a_q     <= ptr_inc(a_q);
			b_q     <= ptr_dec(b_q);
			swaps_q <= swaps_q - 1'b1;
		end
		if (ctrl.cap_tmp) begin
			tmp_q <= ram_rdata;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.load_out && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out && out_free) begin
			out_data_q <= {
				{(OUT_W - WORD_W - KCNT_W - 1 - STAT_W){1'b0}},
				status_q,
				(count_q == '0),
				cx[KCNT_W-1:0],
				((count_q == '0) ? {WORD_W{1'b1}} : ram_rdata)
			};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

[design/cqpr_ram.sv]
// ---------------------------------------------------------------------------
// cqpr_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered and held while
// no read is issued.
// ---------------------------------------------------------------------------
`default_nettype none

module cqpr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[design/cqpr_sequencer.sv]
// ---------------------------------------------------------------------------
// cqpr_sequencer: microcode step counter
// Holds the program step, reads its control word from the program table
// and picks the next step from the condition of that word.
// ---------------------------------------------------------------------------
`default_nettype none

module cqpr_sequencer import cqpr_pkg::*; (
	input  wire    clk,
	input  wire    arst_n,
	input  flags_t flags,
	output ctrl_t  ctrl
);

	step_t step_q;
	step_t step_next;

	assign ctrl = ucode(step_q);

	// Select the next step
	always_comb begin
		step_next = step_q;
		case (ctrl.cond)
			CND_NEXT:     step_next = step_q + 3'd1;
			CND_GOTO:     step_next = ctrl.target;
			CND_DISPATCH: step_next = flags.in_valid ? dispatch(flags.kind) : step_q;
			CND_SWAP:     step_next = flags.swaps_more ? ctrl.target : S_HEAD;
			CND_OUT:      step_next = flags.out_free ? ctrl.target : step_q;
			default:      step_next = S_IDLE;
		endcase
	end

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_next;
		end
	end

endmodule

`default_nettype wire
